>>> rtl/axis_event_conditioner_core_defines.svh
// Assertion macros used by the conditioner sequencer (aec_ctrl).
`ifndef AXIS_EVENT_CONDITIONER_CORE_DEFINES_SVH
`define AXIS_EVENT_CONDITIONER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define AEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Condition that must never be true outside reset.
`define AEC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define AEC_ASSERT(lbl, prop, msg)
`define AEC_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/aec_pkg.sv
// Shared types and constants of the axis event conditioner.
package aec_pkg;

    // Default widths of sample and tick fields
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TICK_BITS_DEF   = 16;

    // Fixed field widths
    localparam int Q_W     = 16;
    localparam int TOL_W   = 16;
    localparam int DB_W    = 15;
    localparam int MOD_W   = 4;
    localparam int CIDX_W  = 3;

    // Quotient bits produced by the serial divider, one per cycle
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_RANGE_MIN = 3'd0;
    localparam logic [CIDX_W-1:0] REG_RANGE_MAX = 3'd1;
    localparam logic [CIDX_W-1:0] REG_CHANGE_TOL = 3'd2;
    localparam logic [CIDX_W-1:0] REG_DEAD_BAND = 3'd3;
    localparam logic [CIDX_W-1:0] REG_REPEAT_INT = 3'd4;
    localparam logic [CIDX_W-1:0] REG_RELATIVE = 3'd5;

    // Register reset values
    localparam logic [TOL_W-1:0] CHANGE_TOL_RST = 16'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic prep;
        logic setup;
        logic div_step;
        logic post;
        logic out_load;
    } aec_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic drop;
        logic fire;
        logic out_busy;
    } aec_status_t;

endpackage

>>> rtl/aec_ctrl.sv
// Sequencer of the axis event conditioner: one item at a time.
`include "axis_event_conditioner_core_defines.svh"

module aec_ctrl
    import aec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  aec_status_t status,
    output aec_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_POST  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 div_last;

    assign div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign s_ready  = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                if (status.drop) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (div_last) begin
                    state_next = S_POST;
                end
            end
            S_POST: begin
                cmd.post   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!status.fire) begin
                    state_next = S_IDLE;
                end else if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `AEC_ASSERT(a_accept_to_prep, (s_valid && s_ready) |=> (state_reg == S_PREP), "transfer did not start evaluation")
    `AEC_ASSERT(a_div_done, (state_reg == S_DIV && div_last) |=> (state_reg == S_POST), "divider overran its step count")
    `AEC_NEVER(a_no_overwrite, cmd.out_load && status.out_busy, "result register overwritten while stalled")

endmodule

>>> rtl/aec_dp.sv
// Datapath: change filter, range mapping divider, deadband, tick accumulator.
module aec_dp
    import aec_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TICK_BITS   = TICK_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  aec_cmd_t                      cmd,
    output aec_status_t                   status,
    // input item
    input  logic signed [SAMPLE_BITS-1:0] s_raw_sample,
    input  logic [TICK_BITS-1:0]          s_elapsed_ticks,
    input  logic [MOD_W-1:0]              s_modifier_bits,
    // configuration
    input  logic signed [SAMPLE_BITS-1:0] range_min,
    input  logic signed [SAMPLE_BITS-1:0] range_max,
    input  logic [TOL_W-1:0]              change_tolerance,
    input  logic [DB_W-1:0]               dead_band,
    input  logic [TICK_BITS-1:0]          repeat_interval,
    input  logic                          relative_mode,
    // result
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [Q_W-1:0]         m_axis_value,
    output logic [MOD_W-1:0]              m_modifier_out,
    output logic                          m_as_offset
);

    localparam int SW = SAMPLE_BITS;
    localparam int AW = TICK_BITS + 1;
    localparam int NW = SW + 19;
    localparam int CW = (SW + 1 > TOL_W) ? SW + 1 : TOL_W;
    localparam int XW = (SW > 17) ? SW : 17;

    // Captured item
    logic signed [SW-1:0]    raw_reg;
    logic [TICK_BITS-1:0]    ticks_reg;
    logic [MOD_W-1:0]        mods_reg;

    // Persistent state
    logic signed [SW-1:0]    last_reg;
    logic                    have_last_reg;
    logic [AW-1:0]           acc_reg;
    logic                    fire_reg;

    // Mapping and divider registers
    logic signed [SW:0]      num_reg;
    logic [SW:0]             den_reg;
    logic                    map_en_reg;
    logic                    neg_reg;
    logic                    over_reg;
    logic [SW:0]             d2_reg;
    logic [SW:0]             rem_reg;
    logic [Q_W-1:0]          quo_reg;
    logic [Q_W-1:0]          v_reg;

    // Result register
    logic                    m_valid_reg;
    logic [Q_W-1:0]          axis_value_reg;
    logic [MOD_W-1:0]        mods_out_reg;
    logic                    as_offset_reg;

    // Change filter
    logic signed [SW:0]      diff;
    logic [SW:0]             diff_mag;
    logic                    drop;

    assign diff     = (SW+1)'(raw_reg) - (SW+1)'(last_reg);
    assign diff_mag = diff[SW] ? (SW+1)'(-diff) : diff;
    assign drop     = !relative_mode && have_last_reg
                      && (CW'(diff_mag) < CW'(change_tolerance));

    // Range offsets, made positive-divisor
    logic signed [SW:0]      num_c;
    logic signed [SW:0]      den_c;

    assign num_c = (SW+1)'(raw_reg) - (SW+1)'(range_min);
    assign den_c = (SW+1)'(range_max) - (SW+1)'(range_min);

    // Saturating tick sum
    logic [AW:0]             acc_sum;
    logic [AW-1:0]           acc_sat;

    assign acc_sum = {1'b0, acc_reg} + (AW+1)'(ticks_reg);
    assign acc_sat = acc_sum[AW] ? '1 : acc_sum[AW-1:0];

    // Divider setup: numerator 131072*num + den over 2*den
    logic [NW-1:0]           n2;
    logic [SW:0]             d2;

    assign n2 = {num_reg[SW], num_reg, 17'd0} + {18'd0, den_reg};
    assign d2 = {den_reg[SW-1:0], 1'b0};

    // One restoring step per cycle
    logic [SW+1:0]           div_t;
    logic [SW+1:0]           div_sub;
    logic                    div_ge;

    assign div_t   = {rem_reg, quo_reg[Q_W-1]};
    assign div_sub = div_t - {1'b0, d2_reg};
    assign div_ge  = (div_t >= {1'b0, d2_reg});

    // Final value: saturate, then deadband
    logic signed [XW-1:0]    rx;
    logic                    sat_hi;
    logic                    sat_lo;
    logic [Q_W-1:0]          unmapped;
    logic [Q_W-1:0]          mapped;
    logic [Q_W-1:0]          v_pre;
    logic [Q_W:0]            v_mag;

    assign rx       = XW'(raw_reg);
    assign sat_hi   = !rx[XW-1] && (|rx[XW-2:Q_W-1]);
    assign sat_lo   = rx[XW-1] && !(&rx[XW-2:Q_W-1]);
    assign unmapped = sat_hi ? 16'h7FFF : (sat_lo ? 16'h8000 : rx[Q_W-1:0]);
    assign mapped   = neg_reg ? 16'h8000
                    : (over_reg ? 16'h7FFF : {~quo_reg[Q_W-1], quo_reg[Q_W-2:0]});
    assign v_pre    = map_en_reg ? mapped : unmapped;
    assign v_mag    = v_pre[Q_W-1] ? ((Q_W+1)'(0) - {1'b1, v_pre}) : {1'b0, v_pre};

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg      <= '0;
            have_last_reg <= 1'b0;
            acc_reg       <= '0;
            fire_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.prep && !drop) begin
                last_reg      <= raw_reg;
                have_last_reg <= 1'b1;
                acc_reg       <= acc_sat;
            end
            if (cmd.setup) begin
                fire_reg <= (acc_reg >= {1'b0, repeat_interval});
                if (acc_reg >= {1'b0, repeat_interval}) begin
                    acc_reg <= acc_reg - {1'b0, repeat_interval};
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            raw_reg   <= s_raw_sample;
            ticks_reg <= s_elapsed_ticks;
            mods_reg  <= s_modifier_bits;
        end
        if (cmd.prep) begin
            map_en_reg <= (range_min != range_max);
            num_reg    <= den_c[SW] ? (SW+1)'(-num_c) : num_c;
            den_reg    <= den_c[SW] ? (SW+1)'(-den_c) : den_c;
        end
        if (cmd.setup) begin
            neg_reg  <= n2[NW-1];
            over_reg <= !n2[NW-1] && (n2 >= {2'd0, d2, 16'd0});
            d2_reg   <= d2;
            rem_reg  <= n2[SW+16:16];
            quo_reg  <= n2[Q_W-1:0];
        end
        if (cmd.div_step) begin
            rem_reg <= div_ge ? div_sub[SW:0] : div_t[SW:0];
            quo_reg <= {quo_reg[Q_W-2:0], div_ge};
        end
        if (cmd.post) begin
            v_reg <= (v_mag < {2'd0, dead_band}) ? '0 : v_pre;
        end
        if (cmd.out_load) begin
            axis_value_reg <= v_reg;
            mods_out_reg   <= mods_reg;
            as_offset_reg  <= relative_mode;
        end
    end

    assign status.drop     = drop;
    assign status.fire     = fire_reg;
    assign status.out_busy = m_valid_reg && !m_ready;

    assign m_valid        = m_valid_reg;
    assign m_axis_value   = axis_value_reg;
    assign m_modifier_out = mods_out_reg;
    assign m_as_offset    = as_offset_reg;

endmodule

>>> rtl/axis_event_conditioner_core.sv
// Top level of the axis event conditioner: register file and sequencer/datapath.
//
// Usage: raw axis samples enter on the s_ channel (valid/ready), conditioned
// results leave on the m_ channel (valid/ready). Each accepted sample is either
// dropped (change below tolerance, absolute mode only) or becomes the new
// reference, is mapped to Q1.15 over [range_min, range_max] (the raw sample
// saturated to 16 bits if the two are equal), deadbanded, and its ticks are
// accumulated; a result is given once accumulated ticks reach repeat_interval.
// Sequence: m_valid rises once a kept sample that fires has passed through
// prepare, setup, 16 divider steps, final value and output load. One sample is
// processed at a time, so a new transfer is taken only back in idle: after
// prepare for a dropped sample, after the output state for a kept one.
// The result sits in an output register, so a stalled receiver holds only the
// next result load; the sequencer then waits and takes no new sample meanwhile.
// Reset (aresetn low, synchronous) sets the configuration registers to defaults,
// forgets the last sample and empties the tick accumulator. Configuration is to be
// written through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module axis_event_conditioner_core
    import aec_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TICK_BITS   = TICK_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [CIDX_W-1:0]             cfg_index,
    input  logic [((SAMPLE_BITS > TICK_BITS) ? ((SAMPLE_BITS > TOL_W) ? SAMPLE_BITS : TOL_W)
                 : ((TICK_BITS > TOL_W) ? TICK_BITS : TOL_W))-1:0] cfg_data,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_raw_sample,
    input  logic [TICK_BITS-1:0]          s_elapsed_ticks,
    input  logic [MOD_W-1:0]              s_modifier_bits,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [Q_W-1:0]         m_axis_value,
    output logic [MOD_W-1:0]              m_modifier_out,
    output logic                          m_as_offset
);

    logic signed [SAMPLE_BITS-1:0] range_min_reg;
    logic signed [SAMPLE_BITS-1:0] range_max_reg;
    logic [TOL_W-1:0]              change_tol_reg;
    logic [DB_W-1:0]               dead_band_reg;
    logic [TICK_BITS-1:0]          repeat_int_reg;
    logic                          relative_reg;

    aec_cmd_t    cmd;
    aec_status_t status;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_min_reg  <= '0;
            range_max_reg  <= '0;
            change_tol_reg <= CHANGE_TOL_RST;
            dead_band_reg  <= '0;
            repeat_int_reg <= '0;
            relative_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RANGE_MIN:  range_min_reg  <= cfg_data[SAMPLE_BITS-1:0];
                REG_RANGE_MAX:  range_max_reg  <= cfg_data[SAMPLE_BITS-1:0];
                REG_CHANGE_TOL: change_tol_reg <= cfg_data[TOL_W-1:0];
                REG_DEAD_BAND:  dead_band_reg  <= cfg_data[DB_W-1:0];
                REG_REPEAT_INT: repeat_int_reg <= cfg_data[TICK_BITS-1:0];
                REG_RELATIVE:   relative_reg   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    aec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    aec_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TICK_BITS   (TICK_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_raw_sample     (s_raw_sample),
        .s_elapsed_ticks  (s_elapsed_ticks),
        .s_modifier_bits  (s_modifier_bits),
        .range_min        (range_min_reg),
        .range_max        (range_max_reg),
        .change_tolerance (change_tol_reg),
        .dead_band        (dead_band_reg),
        .repeat_interval  (repeat_int_reg),
        .relative_mode    (relative_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_axis_value     (m_axis_value),
        .m_modifier_out   (m_modifier_out),
        .m_as_offset      (m_as_offset)
    );

endmodule
